FILE: design/htst_pkg.sv
// ----------------------------------------------------------------------------
// htst_pkg
// Shared types, widths, register codes and the tetrahedron corner patterns
// of the hexahedron to six tetrahedra splitter.
// ----------------------------------------------------------------------------
package htst_pkg;

    // Field widths
    localparam int VERTEX_INDEX_BITS = 24;
    localparam int CELL_INDEX_BITS   = 20;

    // Configuration port
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_DATA_W-1:0] CELLS_X_RESET = CFG_DATA_W'(2);
    localparam logic [CFG_DATA_W-1:0] CELLS_Y_RESET = CFG_DATA_W'(1);

    // Division steps per pipeline stage of the position dividers
    localparam int DIV_STEPS_DEFAULT = 4;

    // Tetrahedra per cell
    localparam int TET_CNT_W = 3;
    localparam logic [TET_CNT_W-1:0] FIRST_TET = 3'd0;
    localparam logic [TET_CNT_W-1:0] LAST_TET  = 3'd5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SWAP_ENABLE = 2'd0,
        REG_CELLS_X     = 2'd1,
        REG_CELLS_Y     = 2'd2
    } t_reg_idx;

    typedef logic [VERTEX_INDEX_BITS-1:0] t_vertex;
    typedef logic [CELL_INDEX_BITS-1:0]   t_cell;
    typedef logic [CFG_DATA_W-1:0]        t_grid_dim;
    typedef t_vertex [7:0]                t_corners;

    typedef struct packed {
        t_cell   cell_index;
        t_vertex corner_0;
        t_vertex corner_1;
        t_vertex corner_2;
        t_vertex corner_3;
        t_vertex corner_4;
        t_vertex corner_5;
        t_vertex corner_6;
        t_vertex corner_7;
    } t_in_item;

    typedef struct packed {
        t_vertex tet_vertex_a;
        t_vertex tet_vertex_b;
        t_vertex tet_vertex_c;
        t_vertex tet_vertex_d;
        t_cell   parent_cell;
        logic    last_of_cell;
    } t_out_item;

    // Cell payload carried alongside the dividers
    typedef struct packed {
        t_corners corners;
        t_cell    cell_idx;
    } t_cell_data;

    // Grid position parities handed to the emitter
    typedef struct packed {
        logic x_odd;
        logic y_odd;
        logic z_odd;
    } t_pos_parity;

    // Corner pattern of one tetrahedron: {a, b, c, d}, three bits each
    function automatic logic [11:0] tet_pattern(input logic mirrored,
                                                input logic [TET_CNT_W-1:0] tet);
        logic [11:0] pat;
        pat = 12'd0;
        case ({mirrored, tet})
            4'b0_000: pat = {3'd0, 3'd5, 3'd1, 3'd6};
            4'b0_001: pat = {3'd0, 3'd1, 3'd3, 3'd6};
            4'b0_010: pat = {3'd1, 3'd3, 3'd6, 3'd2};
            4'b0_011: pat = {3'd6, 3'd3, 3'd0, 3'd7};
            4'b0_100: pat = {3'd6, 3'd7, 3'd0, 3'd5};
            4'b0_101: pat = {3'd7, 3'd5, 3'd4, 3'd0};
            4'b1_000: pat = {3'd0, 3'd5, 3'd6, 3'd1};
            4'b1_001: pat = {3'd0, 3'd1, 3'd6, 3'd3};
            4'b1_010: pat = {3'd1, 3'd3, 3'd2, 3'd6};
            4'b1_011: pat = {3'd6, 3'd3, 3'd7, 3'd0};
            4'b1_100: pat = {3'd6, 3'd7, 3'd5, 3'd0};
            4'b1_101: pat = {3'd7, 3'd5, 3'd0, 3'd4};
            default:  pat = 12'd0;
        endcase
        return pat;
    endfunction

endpackage

FILE: design/hex_to_six_tet_split.sv
// ----------------------------------------------------------------------------
// hex_to_six_tet_split
// Splits each hexahedral grid cell into six tetrahedra, with optional
// corner swapping chosen by the cell's grid position.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one cell per
//   transfer: its linear index and its eight corner vertex indices.
//   Output channel (o_out_valid / i_out_ready / o_out_data) returns six
//   tetrahedra per cell, in order; last_of_cell marks the sixth.
//   Configuration is a write port (i_cfg_we, i_cfg_index, i_cfg_data):
//   0 swap_enable, 1 cells_x, 2 cells_y; a grid size of 0 acts as 1.
//   Write it only while no cell is in flight.
// Path: the two pipelined dividers that find x, y and z from the linear
//   index, then the emitter's cell register, lie between an input transfer
//   and the first tetrahedron of that cell.
// Throughput: the input takes a cell every cycle until the pipeline fills;
//   the sustained rate is set by the single output channel, which sends
//   one tetrahedron per cycle while i_out_ready is high, six per cell.
// Reset: synchronous, active low; empties the pipeline and loads the
//   registers with swap_enable 0, cells_x 2, cells_y 1.
// Stall: a low i_out_ready holds the current tetrahedron; cells then back
//   up through the divider stages and o_in_ready falls, nothing is lost.
// ----------------------------------------------------------------------------
module hex_to_six_tet_split #(
    parameter int DIV_STEPS = htst_pkg::DIV_STEPS_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  htst_pkg::t_in_item                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output htst_pkg::t_out_item                o_out_data,
    input  logic                               i_cfg_we,
    input  logic [htst_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [htst_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import htst_pkg::*;

    localparam int SIDE1_W = $bits(t_cell_data);
    localparam int SIDE2_W = SIDE1_W + 1;

    logic      r_swap_enable;
    t_grid_dim r_cells_x;
    t_grid_dim r_cells_y;

    t_grid_dim  w_div_x;
    t_grid_dim  w_div_y;
    t_cell_data w_cell_data;

    logic               w_d1_valid;
    logic               w_d1_ready;
    t_cell              w_d1_quot;
    t_grid_dim          w_d1_rem;
    logic [SIDE1_W-1:0] w_d1_side;

    logic [SIDE2_W-1:0] w_d2_in_side;
    logic               w_d2_valid;
    logic               w_d2_ready;
    t_cell              w_d2_quot;
    t_grid_dim          w_d2_rem;
    logic [SIDE2_W-1:0] w_d2_side;

    t_cell_data  w_em_data;
    t_pos_parity w_parity;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap_enable <= 1'b0;
            r_cells_x     <= CELLS_X_RESET;
            r_cells_y     <= CELLS_Y_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_SWAP_ENABLE: r_swap_enable <= i_cfg_data[0];
                REG_CELLS_X:     r_cells_x     <= i_cfg_data;
                REG_CELLS_Y:     r_cells_y     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Treat a zero grid size as one
    assign w_div_x = (r_cells_x == '0) ? CFG_DATA_W'(1) : r_cells_x;
    assign w_div_y = (r_cells_y == '0) ? CFG_DATA_W'(1) : r_cells_y;

    // Gather corners in index order
    assign w_cell_data.corners[0] = i_in_data.corner_0;
    assign w_cell_data.corners[1] = i_in_data.corner_1;
    assign w_cell_data.corners[2] = i_in_data.corner_2;
    assign w_cell_data.corners[3] = i_in_data.corner_3;
    assign w_cell_data.corners[4] = i_in_data.corner_4;
    assign w_cell_data.corners[5] = i_in_data.corner_5;
    assign w_cell_data.corners[6] = i_in_data.corner_6;
    assign w_cell_data.corners[7] = i_in_data.corner_7;
    assign w_cell_data.cell_idx   = i_in_data.cell_index;

    // Index / cells_x: remainder is x, quotient is y + cells_y * z
    htst_divider #(
        .NUM_W  (CELL_INDEX_BITS),
        .REM_W  (CFG_DATA_W),
        .STEPS  (DIV_STEPS),
        .SIDE_W (SIDE1_W)
    ) u_div_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_num     (i_in_data.cell_index),
        .i_side    (w_cell_data),
        .i_divisor (w_div_x),
        .o_valid   (w_d1_valid),
        .i_ready   (w_d1_ready),
        .o_quot    (w_d1_quot),
        .o_rem     (w_d1_rem),
        .o_side    (w_d1_side)
    );

    assign w_d2_in_side = {w_d1_rem[0], w_d1_side};

    // Quotient / cells_y: remainder is y, quotient is z
    htst_divider #(
        .NUM_W  (CELL_INDEX_BITS),
        .REM_W  (CFG_DATA_W),
        .STEPS  (DIV_STEPS),
        .SIDE_W (SIDE2_W)
    ) u_div_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_d1_valid),
        .o_ready   (w_d1_ready),
        .i_num     (w_d1_quot),
        .i_side    (w_d2_in_side),
        .i_divisor (w_div_y),
        .o_valid   (w_d2_valid),
        .i_ready   (w_d2_ready),
        .o_quot    (w_d2_quot),
        .o_rem     (w_d2_rem),
        .o_side    (w_d2_side)
    );

    assign w_em_data      = w_d2_side[SIDE1_W-1:0];
    assign w_parity.x_odd = w_d2_side[SIDE1_W];
    assign w_parity.y_odd = w_d2_rem[0];
    assign w_parity.z_odd = w_d2_quot[0];

    htst_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_d2_valid),
        .o_ready       (w_d2_ready),
        .i_data        (w_em_data),
        .i_parity      (w_parity),
        .i_swap_enable (r_swap_enable),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_item        (o_out_data)
    );

endmodule

FILE: design/htst_div_stage.sv
// ----------------------------------------------------------------------------
// htst_div_stage
// One register stage of a pipelined restoring divider: performs STEPS
// quotient bits and carries a pass-through side payload.
// ----------------------------------------------------------------------------
module htst_div_stage #(
    parameter int NUM_W  = 20,
    parameter int REM_W  = 11,
    parameter int STEPS  = 4,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [REM_W-1:0]  i_rem,
    input  logic [SIDE_W-1:0] i_side,
    input  logic [REM_W-1:0]  i_divisor,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [NUM_W-1:0]  o_num,
    output logic [REM_W-1:0]  o_rem,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_valid;
    logic [NUM_W-1:0]  r_num;
    logic [REM_W-1:0]  r_rem;
    logic [SIDE_W-1:0] r_side;
    logic [NUM_W-1:0]  n_num;
    logic [REM_W-1:0]  n_rem;

    // Shift one dividend bit into the remainder per step, subtract when it fits
    always_comb begin
        logic [REM_W:0] v_trial;
        logic           v_q;
        n_num = i_num;
        n_rem = i_rem;
        for (int k = 0; k < STEPS; k++) begin
            v_trial = {n_rem, n_num[NUM_W-1]};
            v_q     = (v_trial >= {1'b0, i_divisor});
            if (v_q) begin
                v_trial = v_trial - {1'b0, i_divisor};
            end
            n_rem = v_trial[REM_W-1:0];
            n_num = {n_num[NUM_W-2:0], v_q};
        end
    end

    // Advance when the stage is empty or its content moves on
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_num  <= n_num;
            r_rem  <= n_rem;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_rem   = r_rem;
    assign o_side  = r_side;

endmodule

FILE: design/htst_divider.sv
// ----------------------------------------------------------------------------
// htst_divider
// Pipelined divider: division stages of STEPS quotient bits (the last takes
// the rest) give quotient and remainder of NUM_W dividend by REM_W divisor.
// ----------------------------------------------------------------------------
module htst_divider #(
    parameter int NUM_W  = 20,
    parameter int REM_W  = 11,
    parameter int STEPS  = 4,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [SIDE_W-1:0] i_side,
    input  logic [REM_W-1:0]  i_divisor,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [NUM_W-1:0]  o_quot,
    output logic [REM_W-1:0]  o_rem,
    output logic [SIDE_W-1:0] o_side
);

    localparam int NUM_STAGES = (NUM_W + STEPS - 1) / STEPS;

    logic              st_valid [NUM_STAGES+1];
    logic              st_ready [NUM_STAGES+1];
    logic [NUM_W-1:0]  st_num   [NUM_STAGES+1];
    logic [REM_W-1:0]  st_rem   [NUM_STAGES+1];
    logic [SIDE_W-1:0] st_side  [NUM_STAGES+1];

    // Feed the dividend with a cleared partial remainder
    assign st_valid[0] = i_valid;
    assign o_ready     = st_ready[0];
    assign st_num[0]   = i_num;
    assign st_rem[0]   = '0;
    assign st_side[0]  = i_side;

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        localparam int LEFT        = NUM_W - g * STEPS;
        localparam int STAGE_STEPS = (LEFT < STEPS) ? LEFT : STEPS;

        htst_div_stage #(
            .NUM_W  (NUM_W),
            .REM_W  (REM_W),
            .STEPS  (STAGE_STEPS),
            .SIDE_W (SIDE_W)
        ) u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (st_valid[g]),
            .o_ready   (st_ready[g]),
            .i_num     (st_num[g]),
            .i_rem     (st_rem[g]),
            .i_side    (st_side[g]),
            .i_divisor (i_divisor),
            .o_valid   (st_valid[g+1]),
            .i_ready   (st_ready[g+1]),
            .o_num     (st_num[g+1]),
            .o_rem     (st_rem[g+1]),
            .o_side    (st_side[g+1])
        );
    end

    assign st_ready[NUM_STAGES] = i_ready;
    assign o_valid = st_valid[NUM_STAGES];
    assign o_quot  = st_num[NUM_STAGES];
    assign o_rem   = st_rem[NUM_STAGES];
    assign o_side  = st_side[NUM_STAGES];

endmodule

FILE: design/htst_emit.sv
// ----------------------------------------------------------------------------
// htst_emit
// Tetrahedron sequencer: holds one cell, derives the corner swap mask and
// pattern choice from the position parities, and sends six tetrahedra.
// ----------------------------------------------------------------------------
module htst_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  htst_pkg::t_cell_data i_data,
    input  htst_pkg::t_pos_parity i_parity,
    input  logic                 i_swap_enable,
    output logic                 o_valid,
    input  logic                 i_ready,
    output htst_pkg::t_out_item  o_item
);

    import htst_pkg::*;

    logic                 r_full;
    logic [TET_CNT_W-1:0] r_tet;
    t_corners             r_corners;
    t_cell                r_cell;
    logic [2:0]           r_mask;
    logic                 r_mirror;

    logic       w_x_sw;
    logic       w_y_sw;
    logic       w_z_sw;
    logic [2:0] n_mask;
    logic       n_mirror;
    logic       w_last;
    logic       w_out_xfer;
    logic [11:0] w_pat;

    // Swaps along x, y and z permute corners by index xor 1, 3 and 4
    assign w_x_sw   = i_swap_enable && !i_parity.x_odd;
    assign w_y_sw   = i_swap_enable && i_parity.y_odd;
    assign w_z_sw   = i_swap_enable && i_parity.z_odd;
    assign n_mask   = {w_z_sw, w_y_sw, w_x_sw ^ w_y_sw};
    assign n_mirror = w_x_sw ^ w_y_sw ^ w_z_sw;

    assign w_last     = (r_tet == LAST_TET);
    assign w_out_xfer = r_full && i_ready;
    assign o_ready    = !r_full || (i_ready && w_last);

    // Step through the six tetrahedra, reload after the last transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_tet  <= FIRST_TET;
        end else if (o_ready) begin
            r_full <= i_valid;
            r_tet  <= FIRST_TET;
        end else if (w_out_xfer) begin
            r_tet  <= r_tet + TET_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_corners <= i_data.corners;
            r_cell    <= i_data.cell_idx;
            r_mask    <= n_mask;
            r_mirror  <= n_mirror;
        end
    end

    // Select the four corners of the current tetrahedron
    assign w_pat = tet_pattern(r_mirror, r_tet);

    always_comb begin
        o_item.tet_vertex_a = r_corners[w_pat[11:9] ^ r_mask];
        o_item.tet_vertex_b = r_corners[w_pat[8:6] ^ r_mask];
        o_item.tet_vertex_c = r_corners[w_pat[5:3] ^ r_mask];
        o_item.tet_vertex_d = r_corners[w_pat[2:0] ^ r_mask];
        o_item.parent_cell  = r_cell;
        o_item.last_of_cell = w_last;
    end

    assign o_valid = r_full;

    // The counter rests at the first tetrahedron while no cell is held
    a_idle_counter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_full |-> (r_tet == FIRST_TET))
        else $error("tetrahedron counter moved without a cell");

    // No new cell is taken before the last tetrahedron leaves
    a_hold_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && !w_last) |-> !o_ready)
        else $error("cell input ready before last tetrahedron");

    // A transfer before the last keeps the same cell on the output
    a_same_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && !w_last) |=> (r_full && $stable(r_cell) && $stable(r_mask)))
        else $error("cell changed in the middle of its run");

    // The counter never runs past the last tetrahedron
    a_tet_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tet <= LAST_TET)
        else $error("tetrahedron counter out of range");

endmodule
